// ===== design/hotp_pkg.sv =====
`default_nettype none
package hotp_pkg;

  localparam int unsigned KeyWords = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CodeW    = 20;

  localparam logic [31:0] IpadWord = 32'h3636_3636;
  localparam logic [31:0] OpadWord = 32'h5c5c_5c5c;
  localparam logic [31:0] PadWord  = 32'h8000_0000;
  localparam logic [31:0] LenInner = 32'd576;
  localparam logic [31:0] LenOuter = 32'd672;
  localparam logic [30:0] CodeMod  = 31'd1000000;

  // Reciprocal of the code modulus, scaled by two to the power RecipShift.
  // It gives the exact quotient for every 31-bit window value.
  localparam logic [31:0] RecipMul   = 32'd2251799814;
  localparam int unsigned RecipShift = 51;

  localparam logic [159:0] Sha1Init =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  // Compression engine states.
  typedef enum logic [1:0] {
    CmpIdle,
    CmpRound,
    CmpAdd
  } cmp_state_e;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    SeqIdle,
    SeqBlock,
    SeqWait,
    SeqTrunc,
    SeqMod,
    SeqOut
  } seq_state_e;

  // Start request to the compression engine.
  typedef struct packed {
    logic         start;
    logic         reinit;
    logic [511:0] block;
  } cmp_req_t;

  // Status back from the compression engine.
  typedef struct packed {
    logic         done;
    logic [159:0] digest;
  } cmp_rsp_t;

endpackage
`default_nettype wire

// ===== design/hotp_sha1_core.sv =====
`default_nettype none
module hotp_sha1_core
  import hotp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmp_req_t req_i,
  output cmp_rsp_t  rsp_o
);

  cmp_state_e    state_q, state_d;
  logic [6:0]    round_q, round_d;
  logic [159:0]  chain_q, chain_d;
  logic [31:0]   a_q, b_q, c_q, d_q, e_q;
  logic [31:0]   a_d, b_d, c_d, d_d, e_d;
  logic [31:0]   w_q [16];
  logic [31:0]   w_new, w_cur, f, k, tmp;
  logic          done_q, done_d;

  // Schedule word for this round; past round 15 it is expanded in place.
  always_comb begin
    w_new = w_q[round_q[3:0] + 4'd13] ^ w_q[round_q[3:0] + 4'd8] ^
            w_q[round_q[3:0] + 4'd2] ^ w_q[round_q[3:0]];
    w_new = {w_new[30:0], w_new[31]};
    w_cur = (round_q < 7'd16) ? w_q[round_q[3:0]] : w_new;
  end

  // Round function and constant.
  always_comb begin
    if (round_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = 32'h5A827999;
    end else if (round_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = 32'h6ED9EBA1;
    end else if (round_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = 32'h8F1BBCDC;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = 32'hCA62C1D6;
    end
    tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_cur;
  end

  // Sequencer: load, 80 rounds, chain add.
  always_comb begin
    state_d = state_q;
    round_d = round_q;
    chain_d = chain_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q;
    done_d = 1'b0;
    case (state_q)
      CmpIdle: begin
        if (req_i.start) begin
          chain_d = req_i.reinit ? Sha1Init : chain_q;
          {a_d, b_d, c_d, d_d, e_d} = chain_d;
          round_d = '0;
          state_d = CmpRound;
        end
      end
      CmpRound: begin
        a_d = tmp;
        b_d = a_q;
        c_d = {b_q[1:0], b_q[31:2]};
        d_d = c_q;
        e_d = d_q;
        round_d = round_q + 7'd1;
        if (round_q == 7'd79) state_d = CmpAdd;
      end
      CmpAdd: begin
        chain_d = {chain_q[159:128] + a_q, chain_q[127:96] + b_q,
                   chain_q[95:64] + c_q, chain_q[63:32] + d_q, chain_q[31:0] + e_q};
        done_d = 1'b1;
        state_d = CmpIdle;
      end
      default: state_d = CmpIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CmpIdle;
      round_q <= '0;
      chain_q <= Sha1Init;
      {a_q, b_q, c_q, d_q, e_q} <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      chain_q <= chain_d;
      a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d;
      done_q  <= done_d;
    end
  end

  // Schedule store: loaded at start, rewritten once per round from round 16 on.
  always_ff @(posedge clk_i) begin
    if (state_q == CmpIdle && req_i.start) begin
      for (int i = 0; i < 16; i++) w_q[i] <= req_i.block[511 - 32*i -: 32];
    end else if (state_q == CmpRound && round_q >= 7'd16) begin
      w_q[round_q[3:0]] <= w_new;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.digest = chain_q;

endmodule
`default_nettype wire

// ===== design/hotp_mod_unit.sv =====
`default_nettype none
module hotp_mod_unit
  import hotp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [30:0] value_i,
  output logic             done_o,
  output logic [CodeW-1:0] rem_o
);

  // Reciprocal multiplication: the quotient comes from the top product bits,
  // then one multiply and subtract leaves the remainder.
  logic [30:0]      val_q;
  logic [62:0]      prod_q;
  logic             mul_q, sub_q, done_q;
  logic [CodeW-1:0] rem_q;
  logic [11:0]      quo;
  logic [30:0]      quo_mod;
  logic [30:0]      diff;

  always_comb begin
    quo     = 12'(prod_q >> RecipShift);
    quo_mod = 31'(quo) * CodeMod;
    diff    = val_q - quo_mod;
  end

  // Stage flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      sub_q  <= mul_q;
      done_q <= sub_q;
    end
  end

  // Data stages.
  always_ff @(posedge clk_i) begin
    if (start_i) val_q <= value_i;
    if (mul_q) prod_q <= {32'd0, val_q} * {31'd0, RecipMul};
    if (sub_q) rem_q <= diff[CodeW-1:0];
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== design/hotp_hmac_sha1_code.sv =====
// Channel  | Direction | Signals
// -------- | --------- | -----------------------------------------------
// counter  | in        | in_valid_i, in_ready_o, moving_counter_i [63:0]
// code     | out       | out_valid_o, out_ready_i, code_o [19:0]
// config   | in        | cfg_we_i, cfg_index_i [2:0], cfg_wdata_i [63:0]
//
// A request is accepted in the idle state, then runs through four SHA-1
// compressions (start, 80 rounds through the shared round unit, chain add,
// handoff), the truncation state, the reciprocal modulo and the output
// state.
// Reset clears the sequencer and the key registers; the next request is taken
// only after the code has been delivered. A stalled output holds the code.
`default_nettype none
module hotp_hmac_sha1_code
  import hotp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [63:0]        moving_counter_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [CodeW-1:0]        code_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]        cfg_wdata_i
);

  logic [63:0]  key_q [KeyWords];
  logic [63:0]  ctr_q;
  logic [159:0] inner_q;
  logic [1:0]   phase_q, phase_d;
  seq_state_e   state_q, state_d;
  logic [30:0]  bin_q;
  logic [CodeW-1:0] code_q;
  cmp_req_t     req;
  cmp_rsp_t     rsp;
  logic         mod_start, mod_done;
  logic [CodeW-1:0] mod_rem;
  logic [511:0] key_blk;
  logic [31:0]  pad;
  logic [3:0]   off;
  logic [159:0] dig_sh;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeyWords; i++) key_q[i] <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  // Block assembly for the current phase.
  always_comb begin
    pad = phase_q[1] ? OpadWord : IpadWord;
    for (int i = 0; i < KeyWords; i++) key_blk[511 - 64*i -: 64] = key_q[i] ^ {pad, pad};
    req.start  = (state_q == SeqBlock);
    req.reinit = !phase_q[0];
    case (phase_q)
      2'd1:    req.block = {ctr_q, PadWord, 384'd0, LenInner};
      2'd3:    req.block = {inner_q, PadWord, 288'd0, LenOuter};
      default: req.block = key_blk;
    endcase
  end

  hotp_sha1_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // Dynamic truncation window.
  always_comb begin
    off    = rsp.digest[3:0];
    dig_sh = rsp.digest << {off, 3'b000};
  end

  assign mod_start = (state_q == SeqTrunc);

  hotp_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .value_i(bin_q),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  // Request sequencer.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    case (state_q)
      SeqIdle:  if (in_valid_i) state_d = SeqBlock;
      SeqBlock: state_d = SeqWait;
      SeqWait: begin
        if (rsp.done) begin
          phase_d = phase_q + 2'd1;
          state_d = (phase_q == 2'd3) ? SeqTrunc : SeqBlock;
        end
      end
      SeqTrunc: state_d = SeqMod;
      SeqMod:   if (mod_done) state_d = SeqOut;
      SeqOut:   if (out_ready_i) state_d = SeqIdle;
      default:  state_d = SeqIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqIdle;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  // Payload registers; the window is taken as the final digest arrives.
  always_ff @(posedge clk_i) begin
    if (state_q == SeqIdle && in_valid_i) ctr_q <= moving_counter_i;
    if (state_q == SeqWait && rsp.done && phase_q == 2'd1) inner_q <= rsp.digest;
    if (state_q == SeqWait && rsp.done && phase_q == 2'd3) bin_q <= dig_sh[158:128];
    if (state_q == SeqMod && mod_done) code_q <= mod_rem;
  end

  assign in_ready_o  = (state_q == SeqIdle);
  assign out_valid_o = (state_q == SeqOut);
  assign code_o      = code_q;

`ifndef NO_ASSERTIONS
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> code_o < 20'd1000000) else $error("code out of range");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken during output");
  a_phase_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> phase_q == 2'd0) else $error("phase not cleared");
`endif

endmodule
`default_nettype wire

// ===== sim/hotp_hmac_sha1_code_tb.sv =====
`timescale 1ns / 1ps

module hotp_hmac_sha1_code_tb;
  import hotp_pkg::*;

  localparam int unsigned LimitCycles = 4000000;
  localparam int unsigned HoldCycles  = 2500;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned PhaseItems  = 116;
  localparam int unsigned RandPhases  = 8;

  // Keeps the key copy, computes one-time codes and compares delivered codes.
  class code_scoreboard;
    bit [63:0]   key[KeyWords];
    int unsigned expected_codes[$];
    int          errors;

    function void set_key(int idx, bit [63:0] val);
      key[idx] = val;
    endfunction

    // One SHA-1 compression of a 512-bit block into a 160-bit chain value.
    function bit [159:0] sha_block(bit [159:0] chain, bit [511:0] blk);
      bit [31:0] w[16];
      bit [31:0] a, b, c, d, e, f, k, tmp, x;
      for (int t = 0; t < 16; t++) w[t] = blk[511-32*t -: 32];
      {a, b, c, d, e} = chain;
      for (int t = 0; t < 80; t++) begin
        if (t >= 16) begin
          x = w[(t-3)&15] ^ w[(t-8)&15] ^ w[(t-14)&15] ^ w[t&15];
          w[t&15] = {x[30:0], x[31]};
        end
        if (t < 20) begin
          f = (b & c) | (~b & d);
          k = 32'h5A827999;
        end else if (t < 40) begin
          f = b ^ c ^ d;
          k = 32'h6ED9EBA1;
        end else if (t < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d;
          k = 32'hCA62C1D6;
        end
        tmp = {a[26:0], a[31:27]} + f + e + k + w[t&15];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = tmp;
      end
      return {chain[159:128] + a, chain[127:96] + b, chain[95:64] + c,
              chain[63:32] + d, chain[31:0] + e};
    endfunction

    // HMAC-SHA1 of the counter, then dynamic truncation to six digits.
    function int unsigned hotp_code(bit [63:0] ctr);
      bit [511:0]  key_blk;
      bit [159:0]  inner, outer;
      bit [31:0]   window;
      int unsigned off;
      key_blk = {key[0], key[1], key[2], key[3], key[4], key[5], key[6], key[7]};
      inner = sha_block(Sha1Init, key_blk ^ {16{IpadWord}});
      inner = sha_block(inner, {ctr, PadWord, 384'b0, LenInner});
      outer = sha_block(Sha1Init, key_blk ^ {16{OpadWord}});
      outer = sha_block(outer, {inner, PadWord, 288'b0, LenOuter});
      off = outer[3:0];
      window = outer[159-8*off -: 32];
      window[31] = 1'b0;
      return window % 1000000;
    endfunction

    function void note_request(bit [63:0] ctr);
      expected_codes.push_back(hotp_code(ctr));
    endfunction

    function void check_code(logic [CodeW-1:0] code);
      int unsigned exp_code;
      if (expected_codes.size() == 0) begin
        $error("code: unexpected result %0d", code);
        errors++;
        return;
      end
      exp_code = expected_codes.pop_front();
      if (code !== exp_code[CodeW-1:0]) begin
        $error("code: expected %0d, actual %0d", exp_code, code);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [63:0]        moving_counter = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CodeW-1:0]   code;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0]        cfg_wdata = '0;

  code_scoreboard sb = new();
  bit             quiet;
  bit             hold_long;
  int unsigned    cycles;

  hotp_hmac_sha1_code i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .moving_counter_i(moving_counter),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .code_o          (code),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none while quiet.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offers one counter request and returns at the edge that accepts it.
  task automatic send_counter(input bit [63:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    moving_counter <= val;
    do @(posedge clk_i); while (!in_ready);
    sb.note_request(val);
  endtask

  // Waits for the block to go idle, then loads all eight key words.
  task automatic load_key(input bit [63:0] kw[KeyWords]);
    in_valid <= 1'b0;
    while (sb.expected_codes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_we <= 1'b1;
    for (int i = 0; i < KeyWords; i++) begin
      cfg_index <= i[CfgIdxW-1:0];
      cfg_wdata <= kw[i];
      sb.set_key(i, kw[i]);
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic bit [63:0] rand_counter(inout bit [63:0] seq);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return rand64();
    if (r < 60) begin
      seq = seq + 1;
      return seq;
    end
    if (r < 80) return 64'($urandom_range(0, 255));
    if (r < 90) return 64'd1 << $urandom_range(0, 63);
    return ~(64'd1 << $urandom_range(0, 63));
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : code_sink
    int unsigned g;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_long = 1'b0;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (g - 1) @(posedge clk_i);
        end
      end
    end
  end

  // Every accepted code is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      sb.check_code(code);
    end
  end

  initial begin : stimulus
    bit [63:0]   kw[KeyWords];
    bit [63:0]   seq;
    int unsigned r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Reset key (all zero): counter extremes and bit patterns.
    send_counter(64'd0);
    send_counter('1);
    send_counter(64'd1);
    send_counter(64'h8000_0000_0000_0000);
    send_counter(64'h5555_5555_5555_5555);
    send_counter(64'hAAAA_AAAA_AAAA_AAAA);

    // The well-known 20-byte test key with counters zero to nine.
    kw = '{64'h3132333435363738, 64'h3930313233343536, 64'h3738393000000000,
           64'd0, 64'd0, 64'd0, 64'd0, 64'd0};
    load_key(kw);
    for (int i = 0; i < 10; i++) send_counter(64'(i));

    // Full-width key of all ones.
    foreach (kw[i]) kw[i] = '1;
    load_key(kw);
    send_counter(64'd0);
    send_counter('1);

    // Random phases under varying keys.
    seq = rand64();
    for (int p = 0; p < RandPhases; p++) begin
      r = $urandom_range(0, 3);
      foreach (kw[i]) begin
        case (r)
          0: kw[i] = rand64();
          1: kw[i] = (i == 0) ? rand64() : 64'd0;
          2: kw[i] = '1;
          default: kw[i] = (p == RandPhases - 1) ? 64'd0 : rand64();
        endcase
      end
      load_key(kw);
      quiet = (p == 3);
      if (p == 1) hold_long = 1'b1;
      for (int n = 0; n < PhaseItems; n++) send_counter(rand_counter(seq));
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (sb.expected_codes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
